FILE: rtl/lcefp_pkg.sv
// Shared constants, codes and types for the longest-common-extension query block.
// No dependencies; imported by lce_fingerprint_table_query_top.
package lcefp_pkg;

    // Fixed field widths of the stream payloads
    localparam int POS_W = 12;
    localparam int LEN_W = 13;

    // Input tdata layout, lowest bit first
    localparam int SA_LO   = 0;
    localparam int LCP_LO  = SA_LO + POS_W;
    localparam int PA_LO   = LCP_LO + LEN_W;
    localparam int PB_LO   = PA_LO + POS_W;
    localparam int IN_USED = PB_LO + POS_W;
    localparam int IN_DATA_W  = ((IN_USED + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((LEN_W + 7) / 8) * 8;

    // Parameter defaults
    localparam int DEF_MAX_LEN = 4096;
    localparam int DEF_LEVELS  = 13;

    // Beat kind carried in tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_QRD,
        S_QCMP,
        S_QEND,
        S_DONE
    } t_state;

endpackage

FILE: rtl/lcefp_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// No dependencies; holds the per-level group id table.
module lcefp_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 53248
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/lce_fingerprint_table_query_top.sv
// Longest-common-extension query engine over a per-level group id table.
// Depends on lcefp_pkg and lcefp_ram.
//
// Usage
//   Slave stream (i_s_*): one beat per item. tuser is the kind: load or query.
//   A load beat carries a suffix start and its LCP with the previous suffix,
//   fed in suffix-array rank order; it gives no result. A query beat carries
//   two positions and gives exactly one master beat (o_m_*) with the common
//   extension length and a flag for a bad position or an incomplete table.
//   i_cfg_we/i_cfg_wdata set the text length (0 taken as 1, saturated at
//   MAX_LEN) and restart loading; write it only while the block is idle.
// Operation (K = levels in use, smallest K with 2^K > length, at most LEVELS)
//   A result beat appears in the cycle in which the slave side is ready again
//   when the master side is free.
//   Load: one table write per level through the single write port, skipped
//   for a start at or past the length. Query: settled at once for bad or equal
//   positions, else each level needs a registered dual read of the table and a
//   compare/add in the shared unit, and the next read address hangs on that
//   add. K = 13 at the full length of 4096.
// Reset clears the length to 1, the group ids, the rank count and the output
// valid flag; table contents stay undefined until loaded. A stalled master side
// holds the result in the output register; the block still takes beats and
// runs loads, and a query waits in its final state for the register to free.
module lce_fingerprint_table_query_top #(
    parameter int MAX_LEN = lcefp_pkg::DEF_MAX_LEN,
    parameter int LEVELS  = lcefp_pkg::DEF_LEVELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration: text length
    input  logic                             i_cfg_we,
    input  logic [lcefp_pkg::LEN_W-1:0]      i_cfg_wdata,
    // Slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: suffix_start[11:0], lcp_value[24:12], pos_a[36:25], pos_b[48:37]
    input  logic [lcefp_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: func (0 load, 1 query)
    input  logic                             i_s_tuser,
    // Master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: ext_length[12:0]
    output logic [lcefp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // tuser: bad_position
    output logic                             o_m_tuser
);

    import lcefp_pkg::*;

    localparam int PW    = $clog2(MAX_LEN);
    localparam int NW    = $clog2(MAX_LEN + 1);
    localparam int LW    = $clog2(LEVELS);
    localparam int KW    = $clog2(LEVELS + 1);
    localparam int SW0   = (LEVELS > NW) ? LEVELS : NW;
    localparam int SW1   = (SW0 > LEN_W) ? SW0 : LEN_W;
    localparam int SW    = SW1 + 1;
    localparam int AW    = LW + PW;
    localparam int DEPTH = LEVELS * (1 << PW);

    // Control and sequencing state
    t_state            r_state, n_state;
    logic [NW-1:0]     r_len, n_len;
    logic [KW-1:0]     r_levels, n_levels;
    logic [NW-1:0]     r_rank, n_rank;
    logic [NW-1:0]     r_gid [LEVELS];
    logic [NW-1:0]     n_gid [LEVELS];
    logic [LW-1:0]     r_lvl, n_lvl;
    logic              r_out_valid, n_out_valid;

    // Item payload and working registers
    logic [SW-1:0]     r_sa, n_sa;
    logic [SW-1:0]     r_lcp, n_lcp;
    logic [SW-1:0]     r_a, n_a;
    logic [SW-1:0]     r_b, n_b;
    logic [LEVELS-1:0] r_t, n_t;
    logic [NW-1:0]     r_limit, n_limit;
    logic              r_inrange, n_inrange;
    logic [NW-1:0]     r_res, n_res;
    logic              r_bad, n_bad;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic              r_out_bad, n_out_bad;

    // Decoded beat and shared-unit signals
    logic              s_accept;
    logic              out_free;
    logic [SW-1:0]     in_sa, in_lcp, in_a, in_b, len_ext;
    logic              q_bad;
    logic              lvl_last;
    logic [SW-1:0]     pa, pb;
    logic [NW-1:0]     gid_new;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [NW-1:0]     rd_a, rd_b;
    logic [SW-1:0]     cfg_v;
    logic [KW-1:0]     cfg_k;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign in_sa    = SW'(i_s_tdata[SA_LO +: POS_W]);
    assign in_lcp   = SW'(i_s_tdata[LCP_LO +: LEN_W]);
    assign in_a     = SW'(i_s_tdata[PA_LO +: POS_W]);
    assign in_b     = SW'(i_s_tdata[PB_LO +: POS_W]);
    assign len_ext  = SW'(r_len);
    assign q_bad    = (r_rank < r_len) || (in_a >= len_ext) || (in_b >= len_ext);
    assign lvl_last = (r_lvl == LW'(r_levels - KW'(1)));

    // Walk addresses: current offset added to both positions
    assign pa = r_a + SW'(r_t);
    assign pb = r_b + SW'(r_t);

    // Group id for the current level: restart at this rank on a short LCP
    assign gid_new = ((r_lcp >> r_lvl) == '0) ? r_rank : r_gid[r_lvl];

    assign ram_we      = (r_state == S_LOAD) && (r_sa < len_ext);
    assign ram_waddr   = {r_lvl, r_sa[PW-1:0]};
    assign ram_raddr_a = {r_lvl, pa[PW-1:0]};
    assign ram_raddr_b = {r_lvl, pb[PW-1:0]};

    lcefp_ram #(
        .WIDTH (NW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (gid_new),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (rd_b)
    );

    // Saturate the written length and count the levels it needs
    always_comb begin
        cfg_v = SW'(i_cfg_wdata);
        if (cfg_v == '0) begin
            cfg_v = SW'(1);
        end
        if (cfg_v > SW'(MAX_LEN)) begin
            cfg_v = SW'(MAX_LEN);
        end
        cfg_k = '0;
        for (int c = 0; c < LEVELS; c++) begin
            if ((SW'(1) << c) < (cfg_v + SW'(1))) begin
                cfg_k = cfg_k + KW'(1);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser == FUNC_QUERY) begin
                        n_state = (q_bad || in_a == in_b) ? S_DONE : S_QRD;
                    end else if (r_rank < r_len) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD:  n_state = lvl_last ? S_IDLE : S_LOAD;
            S_QRD:   n_state = S_QCMP;
            S_QCMP:  n_state = (r_lvl == '0) ? S_QEND : S_QRD;
            S_QEND:  n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_len       = r_len;
        n_levels    = r_levels;
        n_rank      = r_rank;
        n_gid       = r_gid;
        n_lvl       = r_lvl;
        n_sa        = r_sa;
        n_lcp       = r_lcp;
        n_a         = r_a;
        n_b         = r_b;
        n_t         = r_t;
        n_limit     = r_limit;
        n_inrange   = r_inrange;
        n_res       = r_res;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_len   = r_out_len;
        n_out_bad   = r_out_bad;
        o_s_tready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_sa  = in_sa;
                    n_lcp = in_lcp;
                    n_a   = in_a;
                    n_b   = in_b;
                    n_t   = '0;
                    n_bad = q_bad;
                    n_lvl = (i_s_tuser == FUNC_QUERY) ? LW'(r_levels - KW'(1)) : '0;
                    if (q_bad) begin
                        n_res = '0;
                    end else begin
                        n_res = NW'(len_ext - in_a);
                    end
                    n_limit = NW'(len_ext - ((in_a > in_b) ? in_a : in_b));
                end
            end
            S_LOAD: begin
                n_gid[r_lvl] = gid_new;
                if (lvl_last) begin
                    n_rank = r_rank + NW'(1);
                end else begin
                    n_lvl = r_lvl + LW'(1);
                end
            end
            S_QRD: begin
                n_inrange = (pa < len_ext) && (pb < len_ext);
            end
            S_QCMP: begin
                // Shared unit: compare the two ids and advance the offset
                if (r_inrange && rd_a == rd_b) begin
                    n_t = r_t + (LEVELS'(1) << r_lvl);
                end
                n_lvl = r_lvl - LW'(1);
            end
            S_QEND: begin
                n_res = (SW'(r_t) > SW'(r_limit)) ? r_limit : NW'(r_t);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_len   = LEN_W'(r_res);
                    n_out_bad   = r_bad;
                end
            end
            default: ;
        endcase

        // Length write: restart loading
        if (i_cfg_we) begin
            n_len    = NW'(cfg_v);
            n_levels = cfg_k;
            n_rank   = '0;
            for (int c = 0; c < LEVELS; c++) begin
                n_gid[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= NW'(1);
            r_levels    <= KW'(1);
            r_rank      <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < LEVELS; c++) begin
                r_gid[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_levels    <= n_levels;
            r_rank      <= n_rank;
            r_lvl       <= n_lvl;
            r_out_valid <= n_out_valid;
            r_gid       <= n_gid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa      <= n_sa;
        r_lcp     <= n_lcp;
        r_a       <= n_a;
        r_b       <= n_b;
        r_t       <= n_t;
        r_limit   <= n_limit;
        r_inrange <= n_inrange;
        r_res     <= n_res;
        r_bad     <= n_bad;
        r_out_len <= n_out_len;
        r_out_bad <= n_out_bad;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out_len);
    assign o_m_tuser  = r_out_bad;

    // A flagged result carries a zero length
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("flagged result with non-zero length");

    // The rank count never runs past the text length
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rank <= r_len)
        else $error("rank count beyond text length");

    // Level counter stays inside the levels in use while loading or walking
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_QRD) |-> (KW'(r_lvl) < r_levels))
        else $error("level counter out of range");

    // A result is only formed once a query has been taken
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ($past(r_state) == S_DONE || $past(r_state) == S_QEND
                                 || $past(r_state) == S_IDLE))
        else $error("result stage entered from an unexpected state");

endmodule

FILE: tb/testbench.sv
// Self-checking bench for lce_fingerprint_table_query_top: loads suffix/LCP tables and checks
// every extension query against a cycle-free predictor kept here. Depends on lcefp_pkg and the
// block's RTL only.
`timescale 1ns / 1ps

module testbench;

    import lcefp_pkg::*;

    localparam int LEVELS         = DEF_LEVELS;
    localparam int MAX_LEN        = DEF_MAX_LEN;
    localparam int SETTLE_CYCLES  = 40;      // covers the longest load or query
    localparam int RANDOM_ITEMS   = 1550;
    localparam int CALM_ITEMS     = 1350;    // past this, no idling on either side
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PRINT_CAP      = 60;
    localparam int FLAT_LEN       = 600;     // ten levels in use

    typedef struct packed {
        logic            func;
        logic [POS_W-1:0] sa;
        logic [LEN_W-1:0] lcp;
        logic [POS_W-1:0] pa;
        logic [POS_W-1:0] pb;
    } lce_beat_t;

    typedef struct packed {
        logic [LEN_W-1:0] ext_len;
        logic             bad;
    } lce_result_t;

    // Block ports; the driven inputs are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = FUNC_LOAD;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;

    // Stimulus plumbing
    lce_beat_t   beat_q[$];          // beats waiting for the driver
    lce_result_t lce_expected[$];    // answers still owed by the block
    logic        s_taken = 1'b0;     // slave beat accepted at the last rising edge
    bit          calm = 1'b0;
    bit          tx_jitter = 1'b1;
    bit          rx_jitter = 1'b1;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          rx_hold_reqs = 0;
    int          rx_hold_seen = 0;
    int          rx_stall = 0;
    int          mismatches = 0;
    int          stim_count = 0;

    // Predictor state: group id table, running ids per level, load progress, length
    logic [LEN_W-1:0] id_table [LEVELS][MAX_LEN];
    int               run_id [LEVELS];
    int               ranks_loaded;
    bit               table_full;
    int               text_len;

    // Generator's view of the load state, used to keep queries off never-written entries
    bit  written [LEVELS][MAX_LEN];
    int  gen_len = 1;
    int  gen_levels = 1;
    int  gen_rank = 0;
    bit  gen_full = 1'b0;
    bit  gen_whole = 1'b0;
    byte txt [MAX_LEN];
    int  order [MAX_LEN];

    lce_fingerprint_table_query_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Smallest K with 2^K > n, capped at the level count
    function automatic int levels_for(int n);
        int k;
        k = 0;
        while (k < LEVELS && (1 << k) < n + 1) k++;
        return k;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH @%0t: %s got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Rising edge: predictor and checker. Results are compared before the
    // new slave beat is predicted; a query cannot answer in its own cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : track_block
        int          c, k, v, t, pa, pb, a, b, lim, sa, lcp;
        lce_result_t got, want;
        s_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            // reset leaves the table undefined; only the bookkeeping restarts
            text_len = 1;
            ranks_loaded = 0;
            table_full = 1'b0;
            for (c = 0; c < LEVELS; c++) run_id[c] = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.ext_len = o_m_tdata[LEN_W-1:0];
                got.bad = o_m_tuser;
                if (lce_expected.size() == 0) begin
                    report_mismatch("result beat with no query pending", got.ext_len, 0);
                end else begin
                    want = lce_expected.pop_front();
                    if (got.ext_len !== want.ext_len)
                        report_mismatch("ext_length", got.ext_len, want.ext_len);
                    if (got.bad !== want.bad)
                        report_mismatch("bad_position", got.bad, want.bad);
                end
            end
            if (i_cfg_we) begin
                // clamp the length into 1..MAX_LEN and restart loading
                v = i_cfg_wdata;
                if (v == 0) v = 1;
                if (v > MAX_LEN) v = MAX_LEN;
                text_len = v;
                ranks_loaded = 0;
                table_full = 1'b0;
                for (c = 0; c < LEVELS; c++) run_id[c] = 0;
            end
            if (i_s_tvalid && o_s_tready) begin
                k = levels_for(text_len);
                if (i_s_tuser == FUNC_LOAD) begin
                    sa  = i_s_tdata[SA_LO +: POS_W];
                    lcp = i_s_tdata[LCP_LO +: LEN_W];
                    // drop loads once every rank is in
                    if (!table_full && ranks_loaded < text_len) begin
                        for (c = 0; c < k; c++) begin
                            if (lcp < (1 << c)) run_id[c] = ranks_loaded;
                            if (sa < text_len) id_table[c][sa] = run_id[c];
                        end
                        ranks_loaded++;
                        if (ranks_loaded >= text_len) table_full = 1'b1;
                    end
                end else begin
                    a = i_s_tdata[PA_LO +: POS_W];
                    b = i_s_tdata[PB_LO +: POS_W];
                    if (!table_full || a >= text_len || b >= text_len) begin
                        want.ext_len = '0;
                        want.bad = 1'b1;
                    end else if (a == b) begin
                        want.ext_len = LEN_W'(text_len - a);
                        want.bad = 1'b0;
                    end else begin
                        // walk levels from the top; anything at or past the end never matches
                        t = 0;
                        for (c = k - 1; c >= 0; c--) begin
                            pa = a + t;
                            pb = b + t;
                            if (pa < text_len && pb < text_len && id_table[c][pa] == id_table[c][pb])
                                t += 1 << c;
                        end
                        // an inconsistent table may overshoot: clip at the shorter suffix
                        lim = text_len - ((a > b) ? a : b);
                        if (t > lim) t = lim;
                        want.ext_len = LEN_W'(t);
                        want.bad = 1'b0;
                    end
                    lce_expected.push_back(want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Falling edge: slave-side driver. Hold a beat until it is taken, then
    // advance to the next pending beat or idle for a random burst.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_block
        lce_beat_t            nxt;
        logic [IN_DATA_W-1:0] word;
        if (!calm && $urandom_range(0, 63) == 0) tx_jitter = !tx_jitter;
        if (!i_s_tvalid || s_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_s_tvalid <= 1'b0;
            end else if (!calm && tx_jitter && beat_q.size() > 0 && $urandom_range(0, 5) == 0) begin
                // idle this cycle, then for the random gap drawn into tx_gap
                tx_gap = $urandom_range(0, 5);
                i_s_tvalid <= 1'b0;
            end else if (beat_q.size() > 0) begin
                nxt = beat_q.pop_front();
                word = '0;
                word[SA_LO +: POS_W]  = nxt.sa;
                word[LCP_LO +: LEN_W] = nxt.lcp;
                word[PA_LO +: POS_W]  = nxt.pa;
                word[PB_LO +: POS_W]  = nxt.pb;
                i_s_tdata  <= word;
                i_s_tuser  <= nxt.func;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Falling edge: master-side ready. A long hold-off, when requested, is
    // counted here so the block fills up and backs off its slave side.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!calm && $urandom_range(0, 63) == 0) rx_jitter = !rx_jitter;
        if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen = rx_hold_reqs;
            rx_stall = RX_HOLD_CYCLES;
        end
        if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_m_tready <= 1'b0;
        end else if (!calm && rx_jitter && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 5);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. They sample just after the rising edge, when every
    // nonblocking update of that edge has landed.
    // ------------------------------------------------------------------
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (beat_q.size() != 0 || i_s_tvalid || lce_expected.size() != 0);
    endtask

    task automatic set_length(int v);
        wait_drained();
        // a load gives no result beat, so allow the last one to finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= LEN_W'(v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_len    = (v == 0) ? 1 : ((v > MAX_LEN) ? MAX_LEN : v);
        gen_levels = levels_for(gen_len);
        gen_rank   = 0;
        gen_full   = 1'b0;
        gen_whole  = 1'b0;
    endtask

    task automatic queue_load(int sa, int lcp);
        lce_beat_t nb;
        int        c, p;
        nb.func = FUNC_LOAD;
        nb.sa   = POS_W'(sa);
        nb.lcp  = LEN_W'(lcp);
        nb.pa   = POS_W'($urandom);
        nb.pb   = POS_W'($urandom);
        beat_q.push_back(nb);
        if (!gen_full && gen_rank < gen_len) begin
            if (sa < gen_len)
                for (c = 0; c < gen_levels; c++) written[c][sa] = 1'b1;
            gen_rank++;
            stim_count++;
            if (gen_rank >= gen_len) begin
                gen_full = 1'b1;
                gen_whole = 1'b1;
                for (c = 0; c < gen_levels; c++)
                    for (p = 0; p < gen_len; p++)
                        if (!written[c][p]) gen_whole = 1'b0;
            end
        end
    endtask

    task automatic queue_query(int a, int b);
        lce_beat_t nb;
        nb.func = FUNC_QUERY;
        nb.sa   = POS_W'($urandom);
        nb.lcp  = LEN_W'($urandom);
        nb.pa   = POS_W'(a);
        nb.pb   = POS_W'(b);
        beat_q.push_back(nb);
        stim_count++;
    endtask

    task automatic queue_random_query();
        int a, b, r, s;
        r = $urandom_range(0, 99);
        a = $urandom_range(0, gen_len - 1);
        b = $urandom_range(0, gen_len - 1);
        if (gen_full && !gen_whole) begin
            // holes in the table: keep to answers that need no table read
            if (r < 50 || gen_len >= MAX_LEN) b = a;
            else a = $urandom_range(gen_len, MAX_LEN - 1);
        end else if (r < 12 && gen_len < MAX_LEN) begin
            a = $urandom_range(gen_len, MAX_LEN - 1);
            b = $urandom_range(0, MAX_LEN - 1);
        end else if (r < 27) begin
            b = a;
        end else if (r < 37 && a + 1 < gen_len) begin
            b = a + 1;
        end
        if ($urandom_range(0, 1)) begin
            s = a; a = b; b = s;
        end
        queue_query(a, b);
    endtask

    function automatic bit suffix_less(int i, int j, int n);
        int k;
        k = 0;
        while (i + k < n && j + k < n && txt[i+k] == txt[j+k]) k++;
        if (i + k == n) return (j + k != n);
        if (j + k == n) return 1'b0;
        return txt[i+k] < txt[j+k];
    endfunction

    function automatic int shared_prefix(int i, int j, int n);
        int k;
        k = 0;
        while (i + k < n && j + k < n && txt[i+k] == txt[j+k]) k++;
        return k;
    endfunction

    // Build a random text, sort its suffixes and feed the first `keep` ranks
    task automatic queue_text_loads(int n, int alpha, int keep);
        int i, j, cur;
        for (i = 0; i < n; i++) begin
            txt[i] = byte'($urandom_range(0, alpha - 1));
            order[i] = i;
        end
        for (i = 1; i < n; i++) begin
            cur = order[i];
            j = i - 1;
            while (j >= 0 && suffix_less(cur, order[j], n)) begin
                order[j+1] = order[j];
                j--;
            end
            order[j+1] = cur;
        end
        for (i = 0; i < keep; i++) begin
            queue_load(order[i], (i == 0) ? 0 : shared_prefix(order[i-1], order[i], n));
            // now and then ask before the table is complete
            if ($urandom_range(0, 29) == 0) queue_random_query();
        end
    endtask

    task automatic run_random_phase(int idx);
        int kind, n, nq, i, j, s, cnt;
        kind = $urandom_range(0, 99);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 250) : $urandom_range(1, 40);
        if ($urandom_range(0, 19) == 0) set_length(0);
        else set_length(n);
        n = gen_len;
        if (kind < 70) begin
            // well-formed suffix array of a random text, sometimes cut short
            queue_text_loads(n, $urandom_range(1, 4),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n);
        end else if (kind < 85) begin
            // proper permutation, random LCPs: exercises the saturation path
            for (i = 0; i < n; i++) order[i] = i;
            for (i = n - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                s = order[i]; order[i] = order[j]; order[j] = s;
            end
            for (i = 0; i < n; i++)
                queue_load(order[i], $urandom_range(0, 1) ? $urandom_range(0, n)
                                                          : $urandom_range(0, 8191));
        end else begin
            // broken sequence: repeats and starts off the end of the text
            cnt = $urandom_range(1, n + 3);
            for (i = 0; i < cnt; i++)
                queue_load($urandom_range(0, 1) ? $urandom_range(0, n - 1)
                                                : $urandom_range(0, MAX_LEN - 1),
                           $urandom_range(0, 8191));
        end
        if ($urandom_range(0, 3) == 0)
            queue_load($urandom_range(0, MAX_LEN - 1), $urandom_range(0, 8191));
        // one long master-side hold-off, started once the loads are through so the
        // queries that follow meet it
        if (idx == 2) begin
            wait_drained();
            rx_hold_reqs++;
        end
        nq = $urandom_range(8, 30);
        for (i = 0; i < nq; i++) begin
            // once, pause the sender mid-phase until every answer is back
            if (idx == 4 && i == nq / 2) wait_drained();
            queue_random_query();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed corners, a long flat text, then
    // random phases, each opened by a fresh length write.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int r, idx;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // length 1 from reset: ask before loading, load, then corners
        queue_query(0, 0);
        queue_load(0, 0);
        queue_query(0, 0);
        queue_query(0, MAX_LEN - 1);
        queue_query(MAX_LEN - 1, MAX_LEN - 1);
        queue_load(MAX_LEN - 1, MAX_LEN);          // past completion: ignored

        set_length(0);                             // zero is taken as one
        queue_load(0, 0);
        queue_query(0, 0);

        set_length(2);                             // text "aa"
        queue_load(1, 0);
        queue_load(0, 1);
        queue_query(0, 1);
        queue_query(1, 0);
        queue_query(1, 1);

        set_length(3);                             // start off the end is counted, not stored
        queue_load(MAX_LEN - 1, 8191);
        queue_load(2, 0);
        queue_load(0, MAX_LEN);
        queue_random_query();
        queue_query(2, 2);

        set_length(5);                             // permutation with nonsense LCPs
        queue_load(4, 0);
        queue_load(2, 3);
        queue_load(0, 1);
        queue_load(3, 5);
        queue_load(1, 2);
        queue_query(0, 1);

        // over-range write saturates; the table stays incomplete, so every query is flagged
        set_length(8191);
        queue_load(MAX_LEN - 1, 0);
        queue_load(0, 1);
        queue_query(0, 0);
        queue_query(MAX_LEN - 1, 0);
        queue_query(MAX_LEN - 1, MAX_LEN - 1);

        // load "aaa...a" in full so that the upper levels are walked
        set_length(FLAT_LEN);
        for (r = 0; r < FLAT_LEN; r++) queue_load(FLAT_LEN - 1 - r, r);
        queue_query(0, 0);
        queue_query(FLAT_LEN - 1, 0);
        queue_query(0, 1);
        queue_query(FLAT_LEN / 2, FLAT_LEN - 1);
        queue_query(FLAT_LEN - 1, FLAT_LEN - 1);
        queue_query(MAX_LEN / 2, MAX_LEN - 1);
        for (r = 0; r < 20; r++) queue_random_query();

        idx = 0;
        while (stim_count < RANDOM_ITEMS) begin
            if (stim_count > CALM_ITEMS) calm = 1'b1;
            run_random_phase(idx);
            idx++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && lce_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: lce_fingerprint_table_query_top.f
rtl/lcefp_pkg.sv
rtl/lcefp_ram.sv
rtl/lce_fingerprint_table_query_top.sv
tb/testbench.sv
